FILE: sv/sal_pkg.sv
// Package with types and constants shared by the symbol address lookup modules.
package sal_pkg;

  localparam int unsigned MAX_ENTRIES = 65536;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned POS_W = 16;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SHNDX_W = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SHNDX_W-1:0] SECT_UNDEF = 16'h0000;
  localparam logic [SHNDX_W-1:0] SECT_ABS = 16'hfff1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_FORMAT = 4'd1;

  typedef enum logic [1:0] {
    FMT_32 = 2'd0,
    FMT_64 = 2'd1
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CONTAINING = 2'd1,
    KIND_NEAREST = 2'd2
  } kind_t;

  typedef struct packed {
    logic examine;
    logic hit;
    logic lower;
    logic last;
    logic fmt_ok;
    logic [ADDR_W-1:0] value;
    logic [POS_W-1:0] pos;
  } sal_entry_t;

endpackage

FILE: sv/symbol_address_lookup_core.sv
// Top level of the symbol address lookup: front end, queue and back end.
// The last table word of a scan passes the queue; the result word is then held in the
// back end's output register.
// Throughput: one table word per cycle while the queue is not full; the two-entry queue
// and the output register let the front and back ends stall independently.
// Reset (rst_n low, synchronous) clears the entry counter, the found flags, the queue
// pointers and count, the output valid flag and both configuration registers.
module symbol_address_lookup_core (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [sal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sal_pkg::ADDR_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] in_section_index,
  input  logic [63:0] in_symbol_value,
  input  logic [63:0] in_symbol_size,
  input  logic in_last_entry,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_match_kind,
  output logic [15:0] out_match_index
);
  import sal_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  sal_entry_t q_push_entry, q_head_entry;

  sal_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_section_index(in_section_index),
    .in_symbol_value(in_symbol_value),
    .in_symbol_size(in_symbol_size),
    .in_last_entry(in_last_entry),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_push_entry)
  );

  sal_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_entry(q_push_entry),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_head_valid),
    .head_entry(q_head_entry)
  );

  sal_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head_valid(q_head_valid),
    .head_entry(q_head_entry),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_match_kind(out_match_kind),
    .out_match_index(out_match_index)
  );

endmodule

FILE: sv/sal_front.sv
// Front end: configuration registers, entry counter and per-entry classification.
module sal_front (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [sal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sal_pkg::ADDR_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [sal_pkg::SHNDX_W-1:0] in_section_index,
  input  logic [sal_pkg::ADDR_W-1:0] in_symbol_value,
  input  logic [sal_pkg::ADDR_W-1:0] in_symbol_size,
  input  logic in_last_entry,
  input  logic q_full,
  output logic q_push,
  output sal_pkg::sal_entry_t q_entry
);
  import sal_pkg::*;

  logic [ADDR_W-1:0] target_r;
  logic [1:0] format_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] value, size, end_addr;
  logic fmt_ok, sect_ok, in_range, accept;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      format_r <= FMT_32;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TARGET_ADDRESS) begin
        target_r <= cfg_data;
      end else if (cfg_index == CFG_ENTRY_FORMAT) begin
        format_r <= cfg_data[1:0];
      end
    end
  end

  always_comb begin
    fmt_ok = (format_r == FMT_32) || (format_r == FMT_64);
    sect_ok = (in_section_index != SECT_UNDEF) && (in_section_index != SECT_ABS);
    if (format_r == FMT_32) begin
      value = {32'd0, in_symbol_value[31:0]};
      size = {32'd0, in_symbol_size[31:0]};
    end else begin
      value = in_symbol_value;
      size = in_symbol_size;
    end
    end_addr = value + size;
    in_range = (value == target_r) || ((target_r >= value) && (target_r < end_addr));
    q_entry.examine = fmt_ok && sect_ok && (cnt_r < CNT_W'(MAX_ENTRIES));
    q_entry.hit = in_range;
    q_entry.lower = (value <= target_r);
    q_entry.last = in_last_entry;
    q_entry.fmt_ok = fmt_ok;
    q_entry.value = value;
    q_entry.pos = POS_W'(cnt_r);
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_entry) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/sal_queue.sv
// Two-entry queue that decouples the front end from the back end.
module sal_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  sal_pkg::sal_entry_t push_entry,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output sal_pkg::sal_entry_t head_entry
);
  import sal_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  sal_entry_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic do_push, do_pop;

  assign full = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_QW'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_QW'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

FILE: sv/sal_back.sv
// Back end: best-so-far tracking and the registered result word.
module sal_back (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  sal_pkg::sal_entry_t head_entry,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_match_kind,
  output logic [sal_pkg::POS_W-1:0] out_match_index
);
  import sal_pkg::*;

  logic cont_found_r, cont_found_nxt;
  logic [POS_W-1:0] cont_pos_r, cont_pos_nxt;
  logic near_found_r, near_found_nxt;
  logic [POS_W-1:0] near_pos_r, near_pos_nxt;
  logic [ADDR_W-1:0] near_addr_r, near_addr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [POS_W-1:0] index_r, index_nxt;

  assign out_valid = out_valid_r;
  assign out_match_kind = kind_r;
  assign out_match_index = index_r;
  assign pop = head_valid && (!head_entry.last || !out_valid_r || out_ready);

  always_comb begin
    cont_found_nxt = cont_found_r;
    cont_pos_nxt = cont_pos_r;
    near_found_nxt = near_found_r;
    near_pos_nxt = near_pos_r;
    near_addr_nxt = near_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt = kind_r;
    index_nxt = index_r;
    if (pop) begin
      if (head_entry.examine && head_entry.hit && !cont_found_r) begin
        cont_found_nxt = 1'b1;
        cont_pos_nxt = head_entry.pos;
      end
      if (head_entry.examine && head_entry.lower &&
          (!near_found_r || (head_entry.value > near_addr_r))) begin
        near_found_nxt = 1'b1;
        near_pos_nxt = head_entry.pos;
        near_addr_nxt = head_entry.value;
      end
      if (head_entry.last) begin
        out_valid_nxt = 1'b1;
        kind_nxt = KIND_NONE;
        index_nxt = '0;
        if (head_entry.fmt_ok) begin
          if (cont_found_nxt) begin
            kind_nxt = KIND_CONTAINING;
            index_nxt = cont_pos_nxt;
          end else if (near_found_nxt) begin
            kind_nxt = KIND_NEAREST;
            index_nxt = near_pos_nxt;
          end
        end
        cont_found_nxt = 1'b0;
        cont_pos_nxt = '0;
        near_found_nxt = 1'b0;
        near_pos_nxt = '0;
        near_addr_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_found_r <= 1'b0;
      near_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cont_found_r <= cont_found_nxt;
      near_found_r <= near_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cont_pos_r <= cont_pos_nxt;
    near_pos_r <= near_pos_nxt;
    near_addr_r <= near_addr_nxt;
    kind_r <= kind_nxt;
    index_r <= index_nxt;
  end

`ifndef SYNTH
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (kind_r != 2'd3)) else $error("illegal match kind");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_entry.last) |=> (!cont_found_r && !near_found_r))
    else $error("scan state not cleared after last word");
  a_none_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == KIND_NONE)) |-> (index_r == '0))
    else $error("nonzero index with no match");
`endif

endmodule
